// ----- rtl/fswb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswb_pkg
// shared widths, codes and types of the flash sector write-back cache
// ----------------------------------------------------------------------------
package fswb_pkg;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 8;
    localparam int KIND_W = 3;
    localparam int SIDX_W = 12;
    localparam int CFG_W  = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int DEF_SECTOR_BYTES = 4096;
    localparam int DEF_ADDRESS_BITS = 24;
    localparam logic [CFG_W-1:0] DEF_FLUSH_DELAY = 8'd20;

    // register index, taken from paddr[2]
    localparam logic REG_FLUSH_DELAY = 1'b0;

    // input operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] K_READ_DATA  = 3'd0;
    localparam logic [KIND_W-1:0] K_READ_FLASH = 3'd1;
    localparam logic [KIND_W-1:0] K_ERASE      = 3'd2;
    localparam logic [KIND_W-1:0] K_PROGRAM    = 3'd3;
    localparam logic [KIND_W-1:0] K_LOAD       = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIDX_W-1:0] sector_index;
        logic [ADDR_W-1:0] flash_address;
    } res_t;

endpackage

// ----- rtl/fswb_buf_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswb_buf_mem
// sector byte buffer: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fswb_buf_mem
    import fswb_pkg::*;
#(
    parameter int DEPTH = DEF_SECTOR_BYTES
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/fswb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswb_ctrl
// sector cache controller: flags, countdown, command list and result register
// ----------------------------------------------------------------------------
module fswb_ctrl
    import fswb_pkg::*;
#(
    parameter int SECTOR_BYTES = DEF_SECTOR_BYTES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  flush_delay,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] data,
    input  logic              end_of_transfer,
    input  logic              flash_busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] kind,
    output logic [SIDX_W-1:0] sector_index,
    output logic [ADDR_W-1:0] flash_address,
    output logic [DATA_W-1:0] read_data,
    output logic              last
);

    localparam int OFF_W    = $clog2(SECTOR_BYTES);
    localparam int SEC_W    = ADDR_W - OFF_W;
    localparam int EFF_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'd1 << EFF_BITS) - 64'd1);
    localparam int PLAN_N = 3;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PEND = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg,   state_next;
    logic [SEC_W-1:0]  held_reg,    held_next;
    logic              holds_reg,   holds_next;
    logic              dirty_reg,   dirty_next;
    logic              erased_reg,  erased_next;
    logic [CFG_W-1:0]  cd_reg,      cd_next;
    logic              loading_reg, loading_next;
    logic [OFF_W-1:0]  poff_reg,    poff_next;
    logic [DATA_W-1:0] pbyte_reg,   pbyte_next;
    logic [1:0]        cnt_reg,     cnt_next;
    logic [1:0]        idx_reg,     idx_next;
    res_t              plan_reg [PLAN_N];
    res_t              plan_next [PLAN_N];
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg,   out_res_next;
    logic [DATA_W-1:0] out_rdata_reg, out_rdata_next;
    logic              out_last_reg,  out_last_next;

    logic [ADDR_W-1:0] addr_m;
    logic [OFF_W-1:0]  off;
    logic [SEC_W-1:0]  sec;
    logic [ADDR_W-1:0] held_base;
    logic [ADDR_W-1:0] new_base;
    logic              hit;
    logic [CFG_W-1:0]  cd_dec;
    logic [1:0]        n;
    logic              emit_ld;

    logic              mem_we;
    logic [OFF_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;

    fswb_buf_mem #(
        .DEPTH (SECTOR_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (off),
        .rd_data (mem_rdata)
    );

    assign addr_m    = address & AMASK;
    assign off       = addr_m[OFF_W-1:0];
    assign sec       = addr_m[ADDR_W-1:OFF_W];
    assign held_base = {held_reg, {OFF_W{1'b0}}};
    assign new_base  = {sec, {OFF_W{1'b0}}};
    assign hit       = holds_reg && !loading_reg && (sec == held_reg);
    assign cd_dec    = cd_reg - 8'd1;
    assign in_ready  = (state_reg == S_IDLE);
    assign mem_re    = in_valid && in_ready && (operation == OP_READ) && hit;
    assign emit_ld   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        holds_next   = holds_reg;
        dirty_next   = dirty_reg;
        erased_next  = erased_reg;
        cd_next      = cd_reg;
        loading_next = loading_reg;
        poff_next    = poff_reg;
        pbyte_next   = pbyte_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        plan_next    = plan_reg;
        n            = 2'd0;
        mem_we       = 1'b0;
        mem_waddr    = off;
        mem_wdata    = data;

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_rdata_next = out_rdata_reg;
        out_last_next  = out_last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        OP_WRITE:
                        begin
                            if (!loading_reg)
                            begin
                                if (hit)
                                begin
                                    mem_we     = 1'b1;
                                    dirty_next = 1'b1;
                                    if (!erased_reg)
                                    begin
                                        plan_next[n] = '{K_ERASE, SIDX_W'(held_reg), held_base};
                                        n = n + 2'd1;
                                        erased_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    if (holds_reg && dirty_reg)
                                    begin
                                        if (!erased_reg)
                                        begin
                                            plan_next[n] = '{K_ERASE, SIDX_W'(held_reg),
                                                             held_base};
                                            n = n + 2'd1;
                                        end
                                        plan_next[n] = '{K_PROGRAM, SIDX_W'(held_reg),
                                                         held_base};
                                        n = n + 2'd1;
                                    end
                                    plan_next[n] = '{K_LOAD, SIDX_W'(sec), new_base};
                                    n = n + 2'd1;
                                    held_next    = sec;
                                    holds_next   = 1'b1;
                                    dirty_next   = 1'b0;
                                    erased_next  = 1'b0;
                                    loading_next = 1'b1;
                                    poff_next    = off;
                                    pbyte_next   = data;
                                end
                                if (end_of_transfer)
                                begin
                                    cd_next = flush_delay;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            // read data itself comes from the buffer's registered read port
                            if (hit)
                            begin
                                plan_next[n] = '{K_READ_DATA, SIDX_W'(held_reg), addr_m};
                            end
                            else
                            begin
                                plan_next[n] = '{K_READ_FLASH, SIDX_W'(sec), addr_m};
                            end
                            n = n + 2'd1;
                        end
                        OP_TICK:
                        begin
                            if (!loading_reg && (cd_reg != '0))
                            begin
                                cd_next = cd_dec;
                                if ((cd_dec == '0) && dirty_reg)
                                begin
                                    if (flash_busy)
                                    begin
                                        cd_next = 8'd1;
                                    end
                                    else
                                    begin
                                        plan_next[n] = '{K_PROGRAM, SIDX_W'(held_reg),
                                                         held_base};
                                        n = n + 2'd1;
                                        dirty_next  = 1'b0;
                                        erased_next = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_FILL:
                        begin
                            if (loading_reg)
                            begin
                                mem_we = 1'b1;
                                if (off == {OFF_W{1'b1}})
                                begin
                                    loading_next = 1'b0;
                                    dirty_next   = 1'b1;
                                    if (!erased_reg)
                                    begin
                                        plan_next[n] = '{K_ERASE, SIDX_W'(held_reg), held_base};
                                        n = n + 2'd1;
                                        erased_next = 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    cnt_next = n;
                    idx_next = 2'd0;
                    if ((operation == OP_FILL) && loading_reg && (off == {OFF_W{1'b1}}))
                    begin
                        state_next = S_PEND;
                    end
                    else if (n != 2'd0)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_PEND:
            begin
                // the held write byte lands on top of the loaded sector
                mem_we    = 1'b1;
                mem_waddr = poff_reg;
                mem_wdata = pbyte_reg;
                state_next = (cnt_reg != 2'd0) ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (emit_ld)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = plan_reg[idx_reg];
                    out_rdata_next = (plan_reg[idx_reg].kind == K_READ_DATA) ? mem_rdata : '0;
                    out_last_next  = (idx_reg == (cnt_reg - 2'd1));
                    idx_next       = idx_reg + 2'd1;
                    if (idx_reg == (cnt_reg - 2'd1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            holds_reg     <= 1'b0;
            dirty_reg     <= 1'b0;
            erased_reg    <= 1'b0;
            cd_reg        <= '0;
            loading_reg   <= 1'b0;
            poff_reg      <= '0;
            pbyte_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            holds_reg     <= holds_next;
            dirty_reg     <= dirty_next;
            erased_reg    <= erased_next;
            cd_reg        <= cd_next;
            loading_reg   <= loading_next;
            poff_reg      <= poff_next;
            pbyte_reg     <= pbyte_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg      <= plan_next;
        out_res_reg   <= out_res_next;
        out_rdata_reg <= out_rdata_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_res_reg.kind;
    assign sector_index  = out_res_reg.sector_index;
    assign flash_address = out_res_reg.flash_address;
    assign read_data     = out_rdata_reg;
    assign last          = out_last_reg;

endmodule

// ----- rtl/flash_sector_write_back_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_sector_write_back_cache_unit
// single-sector write-back cache in front of a serial flash, with apb setup
// ----------------------------------------------------------------------------
//  channel  | signals                              | transfer when
//  ---------+--------------------------------------+---------------------------
//  input    | in_valid/in_ready + item fields      | in_valid & in_ready
//  output   | out_valid/out_ready + result fields  | out_valid & out_ready
//  config   | psel/penable/pwrite/paddr/pwdata     | psel & penable & pwrite
//
//  an item is taken only in the idle step; each result it causes then leaves
//  through the result register, and no new item is taken until its last
//  result is loaded (a fill that ends a load first writes the held byte)
//  reads of the buffer go through its registered read port
//  reset clears state, flags, countdown and counters; buffer contents stay undefined
//  a stalled output holds the controller in its emit step, input not taken
// ----------------------------------------------------------------------------
module flash_sector_write_back_cache_unit
    import fswb_pkg::*;
#(
    parameter int SECTOR_BYTES = DEF_SECTOR_BYTES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] data,
    input  logic              end_of_transfer,
    input  logic              flash_busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] kind,
    output logic [SIDX_W-1:0] sector_index,
    output logic [ADDR_W-1:0] flash_address,
    output logic [DATA_W-1:0] read_data,
    output logic              last
);

    logic [CFG_W-1:0] flush_delay_reg, flush_delay_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        flush_delay_next = flush_delay_reg;
        if (cfg_wr && (paddr[2] == REG_FLUSH_DELAY))
        begin
            flush_delay_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_delay_reg <= DEF_FLUSH_DELAY;
        end
        else
        begin
            flush_delay_reg <= flush_delay_next;
        end
    end

    assign prdata = (paddr[2] == REG_FLUSH_DELAY) ? APB_DW'(flush_delay_reg) : '0;

    fswb_ctrl #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .flush_delay     (flush_delay_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .address         (address),
        .data            (data),
        .end_of_transfer (end_of_transfer),
        .flash_busy      (flash_busy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .sector_index    (sector_index),
        .flash_address   (flash_address),
        .read_data       (read_data),
        .last            (last)
    );

endmodule

// ----- tb/fswb_cache_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fswb_cache_checker
// follows every item, config and result transfer of the sector cache, keeps
// its own copy of the cache state and compares results in order, field by field
// ----------------------------------------------------------------------------
module fswb_cache_checker
    import fswb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] data,
    input  logic              end_of_transfer,
    input  logic              flash_busy,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [SIDX_W-1:0] sector_index,
    input  logic [ADDR_W-1:0] flash_address,
    input  logic [DATA_W-1:0] read_data,
    input  logic              last,
    output int                mismatches,
    output int                outstanding
);

    localparam int OFF_W = $clog2(DEF_SECTOR_BYTES);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIDX_W-1:0] sector;
        logic [ADDR_W-1:0] faddr;
        logic [DATA_W-1:0] rdata;
        logic              last;
    } flash_cmd_t;

    logic [DATA_W-1:0] line_copy [DEF_SECTOR_BYTES];
    logic [SIDX_W-1:0] cached_sector = '0;
    logic              cache_valid   = 1'b0;
    logic              cache_dirty   = 1'b0;
    logic              cache_erased  = 1'b0;
    logic              fill_active   = 1'b0;
    logic [CFG_W-1:0]  wb_countdown  = '0;
    logic [CFG_W-1:0]  wb_delay      = DEF_FLUSH_DELAY;
    logic [OFF_W-1:0]  held_off      = '0;
    logic [DATA_W-1:0] held_byte     = '0;
    flash_cmd_t        flash_cmd_q [$];
    int                fail_count    = 0;

    assign mismatches = fail_count;

    function automatic flash_cmd_t make_cmd(input logic [KIND_W-1:0] k,
                                            input logic [SIDX_W-1:0] s,
                                            input logic [ADDR_W-1:0] fa,
                                            input logic [DATA_W-1:0] rd);
        flash_cmd_t c;
        c.kind   = k;
        c.sector = s;
        c.faddr  = fa;
        c.rdata  = rd;
        c.last   = 1'b0;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] sector_base(input logic [SIDX_W-1:0] s);
        return {s, {OFF_W{1'b0}}};
    endfunction

    // applies one accepted item to the copy of the cache and queues its results
    task automatic cache_step(input logic [1:0]        op,
                              input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] din,
                              input logic              eot,
                              input logic              busy);
        logic [SIDX_W-1:0] sec;
        logic [OFF_W-1:0]  off;
        logic              hit;
        flash_cmd_t        burst [$];
        flash_cmd_t        c;
        sec = addr[ADDR_W-1:OFF_W];
        off = addr[OFF_W-1:0];
        hit = cache_valid && !fill_active && sec == cached_sector;
        case (op)
            OP_WRITE:
            begin
                if (!fill_active)
                begin
                    if (hit)
                    begin
                        line_copy[off] = din;
                        cache_dirty = 1'b1;
                        if (!cache_erased)
                        begin
                            burst.push_back(make_cmd(K_ERASE, cached_sector,
                                                     sector_base(cached_sector), '0));
                            cache_erased = 1'b1;
                        end
                    end
                    else
                    begin
                        // miss: write back the dirty sector, then fetch the new one
                        if (cache_valid && cache_dirty)
                        begin
                            if (!cache_erased)
                                burst.push_back(make_cmd(K_ERASE, cached_sector,
                                                         sector_base(cached_sector), '0));
                            burst.push_back(make_cmd(K_PROGRAM, cached_sector,
                                                     sector_base(cached_sector), '0));
                        end
                        cached_sector = sec;
                        cache_valid   = 1'b1;
                        cache_dirty   = 1'b0;
                        cache_erased  = 1'b0;
                        fill_active   = 1'b1;
                        held_off      = off;
                        held_byte     = din;
                        burst.push_back(make_cmd(K_LOAD, sec, sector_base(sec), '0));
                    end
                    if (eot)
                        wb_countdown = wb_delay;
                end
            end
            OP_READ:
            begin
                if (hit)
                    burst.push_back(make_cmd(K_READ_DATA, cached_sector, addr,
                                             line_copy[off]));
                else
                    burst.push_back(make_cmd(K_READ_FLASH, sec, addr, '0));
            end
            OP_TICK:
            begin
                if (!fill_active && wb_countdown != '0)
                begin
                    wb_countdown = wb_countdown - 8'd1;
                    if (wb_countdown == '0 && cache_dirty)
                    begin
                        if (busy)
                            wb_countdown = 8'd1;
                        else
                        begin
                            burst.push_back(make_cmd(K_PROGRAM, cached_sector,
                                                     sector_base(cached_sector), '0));
                            cache_dirty  = 1'b0;
                            cache_erased = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                if (fill_active)
                begin
                    line_copy[off] = din;
                    // last offset ends the load and drops in the held byte
                    if (off == {OFF_W{1'b1}})
                    begin
                        fill_active = 1'b0;
                        line_copy[held_off] = held_byte;
                        cache_dirty = 1'b1;
                        if (!cache_erased)
                        begin
                            burst.push_back(make_cmd(K_ERASE, cached_sector,
                                                     sector_base(cached_sector), '0));
                            cache_erased = 1'b1;
                        end
                    end
                end
            end
        endcase
        foreach (burst[i])
        begin
            c = burst[i];
            c.last = (i == burst.size() - 1);
            flash_cmd_q.push_back(c);
        end
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want != got)
        begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        flash_cmd_t want;
        if (!rst_n)
        begin
            cached_sector = '0;
            cache_valid   = 1'b0;
            cache_dirty   = 1'b0;
            cache_erased  = 1'b0;
            fill_active   = 1'b0;
            wb_countdown  = '0;
            wb_delay      = DEF_FLUSH_DELAY;
            held_off      = '0;
            held_byte     = '0;
            flash_cmd_q.delete();
        end
        else
        begin
            // results first, so a result can never match an item of this same edge
            if (out_valid && out_ready)
            begin
                if (flash_cmd_q.size() == 0)
                begin
                    $error("unexpected result transfer, kind 0x%0h", kind);
                    fail_count++;
                end
                else
                begin
                    want = flash_cmd_q.pop_front();
                    check_field("kind", ADDR_W'(want.kind), ADDR_W'(kind));
                    check_field("sector_index", ADDR_W'(want.sector),
                                ADDR_W'(sector_index));
                    check_field("flash_address", want.faddr, flash_address);
                    check_field("read_data", ADDR_W'(want.rdata), ADDR_W'(read_data));
                    check_field("last", ADDR_W'(want.last), ADDR_W'(last));
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_FLUSH_DELAY)
                wb_delay = pwdata[CFG_W-1:0];
            if (in_valid && in_ready)
                cache_step(operation, address, data, end_of_transfer, flash_busy);
        end
        outstanding <= flash_cmd_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random byte writes, reads, ticks and fills into the
// sector cache under several flush delays, with bursty input and a stalling
// result side; the checker beside the cache judges every result
// ----------------------------------------------------------------------------
module tb_top
    import fswb_pkg::*;
();

    localparam int OFF_W          = $clog2(DEF_SECTOR_BYTES);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 29;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [APB_AW-1:0] paddr           = '0;
    logic [APB_DW-1:0] pwdata          = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid        = 1'b0;
    logic              in_ready;
    logic [1:0]        operation       = OP_READ;
    logic [ADDR_W-1:0] address         = '0;
    logic [DATA_W-1:0] data            = '0;
    logic              end_of_transfer = 1'b0;
    logic              flash_busy      = 1'b0;
    logic              out_valid;
    logic              out_ready       = 1'b1;
    logic [KIND_W-1:0] kind;
    logic [SIDX_W-1:0] sector_index;
    logic [ADDR_W-1:0] flash_address;
    logic [DATA_W-1:0] read_data;
    logic              last;
    int                mismatches;
    int                outstanding;

    // what the stimulus has set up so far, to keep reads off unwritten bytes
    logic              shadow_valid   = 1'b0;
    logic              shadow_loading = 1'b0;
    logic [SIDX_W-1:0] shadow_sector  = '0;
    logic [OFF_W-1:0]  shadow_held    = '0;
    bit                byte_set [DEF_SECTOR_BYTES];
    logic [OFF_W-1:0]  set_offsets [$];

    int burst_left  = 0;
    int quiet_count = 0;
    int stall_mode  = 0;
    int stall_span  = 0;

    flash_sector_write_back_cache_unit uut (.*);

    fswb_cache_checker checker_i (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    // result side: changes its stall pattern after each random span
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 80);
        end
        else
            stall_span = stall_span - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((stall_span % 8) >= 6);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic mark_byte(input logic [OFF_W-1:0] off);
        if (!byte_set[off])
        begin
            byte_set[off] = 1'b1;
            set_offsets.push_back(off);
        end
    endtask

    task automatic send_item(input logic [1:0]        op,
                             input logic [ADDR_W-1:0] addr_in,
                             input logic [DATA_W-1:0] din,
                             input logic              eot,
                             input logic              busy);
        logic [ADDR_W-1:0] addr;
        logic [SIDX_W-1:0] sec;
        logic [OFF_W-1:0]  off;
        logic              hit;
        int                gap;
        addr = addr_in;
        sec  = addr[ADDR_W-1:OFF_W];
        off  = addr[OFF_W-1:0];
        hit  = shadow_valid && !shadow_loading && sec == shadow_sector;
        // a read hit must land on a byte that has been written
        if (op == OP_READ && hit && !byte_set[off])
        begin
            if (set_offsets.size() > 0)
                off = set_offsets[$urandom_range(0, set_offsets.size() - 1)];
            else
            begin
                sec = sec ^ SIDX_W'(1);
                hit = 1'b0;
            end
            addr = {sec, off};
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        operation       <= op;
        address         <= addr;
        data            <= din;
        end_of_transfer <= eot;
        flash_busy      <= busy;
        do @(posedge clk); while (!in_ready);
        case (op)
            OP_WRITE:
            begin
                if (!shadow_loading)
                begin
                    if (hit)
                        mark_byte(off);
                    else
                    begin
                        shadow_valid   = 1'b1;
                        shadow_loading = 1'b1;
                        shadow_sector  = sec;
                        shadow_held    = off;
                    end
                end
            end
            OP_FILL:
            begin
                if (shadow_loading)
                begin
                    mark_byte(off);
                    if (off == {OFF_W{1'b1}})
                    begin
                        shadow_loading = 1'b0;
                        mark_byte(shadow_held);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [SIDX_W-1:0] pick_sector();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return shadow_sector + SIDX_W'(1);
            default: return SIDX_W'($urandom_range(0, (1 << SIDX_W) - 1));
        endcase
    endfunction

    // mostly well-formed traffic: hits on the held sector, loads that get filled
    task automatic random_item();
        logic [1:0]        op;
        logic [SIDX_W-1:0] sec;
        logic [OFF_W-1:0]  off;
        int                pick;
        pick = $urandom_range(0, 99);
        sec  = pick_sector();
        off  = OFF_W'($urandom_range(0, DEF_SECTOR_BYTES - 1));
        if (shadow_loading)
        begin
            if (pick < 65)
            begin
                op = OP_FILL;
                if ($urandom_range(0, 4) == 0)
                    off = '1;
            end
            else if (pick < 75)
                op = OP_WRITE;
            else if (pick < 90)
                op = OP_READ;
            else
                op = OP_TICK;
        end
        else
        begin
            if (pick < 35)
            begin
                op = OP_WRITE;
                if ($urandom_range(0, 4) != 0)
                    sec = shadow_sector;
            end
            else if (pick < 60)
            begin
                op  = OP_READ;
                sec = shadow_sector;
                if (set_offsets.size() > 0)
                    off = set_offsets[$urandom_range(0, set_offsets.size() - 1)];
            end
            else if (pick < 67)
                op = OP_READ;
            else if (pick < 92)
                op = OP_TICK;
            else
                op = OP_FILL;
        end
        send_item(op, {sec, off}, DATA_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
    endtask

    task automatic set_flush_delay(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FLUSH_DELAY, 2'b00};
        pwdata  <= {{(APB_DW - CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending, let every expected result out, then let the cache settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase_delay [5];
        phase_delay = '{1, 255, 0, 3, 20};
        phase_delay[4] = $urandom_range(1, 255);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_flush_delay(8'd2);

        send_item(OP_READ,  24'h000000, 8'h00, 1'b0, 1'b0);  // nothing held yet
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b0);
        send_item(OP_FILL,  24'h000FFF, 8'hFF, 1'b1, 1'b1);  // fill with no load
        send_item(OP_WRITE, 24'h000005, 8'hA5, 1'b1, 1'b0);  // miss on empty cache
        send_item(OP_WRITE, 24'h000007, 8'h77, 1'b0, 1'b0);  // dropped while loading
        send_item(OP_READ,  24'h000005, 8'h00, 1'b0, 1'b0);  // referred while loading
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b0);  // countdown held
        send_item(OP_FILL,  24'hFFF005, 8'h11, 1'b0, 1'b0);
        send_item(OP_FILL,  24'h000FFE, 8'hFF, 1'b0, 1'b0);
        send_item(OP_FILL,  24'h000FFF, 8'h00, 1'b0, 1'b0);  // ends load
        send_item(OP_READ,  24'h000005, 8'h00, 1'b0, 1'b0);  // held byte wins
        send_item(OP_READ,  24'h000FFF, 8'h00, 1'b0, 1'b0);
        send_item(OP_WRITE, 24'h000FFE, 8'h5A, 1'b1, 1'b0);
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b0);
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b1);  // busy, retry
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b0);  // timed write-back
        send_item(OP_WRITE, 24'h000010, 8'hC3, 1'b0, 1'b0);  // hit needs erase again
        send_item(OP_WRITE, 24'hFFFFFF, 8'hFF, 1'b1, 1'b0);  // dirty miss
        send_item(OP_FILL,  24'h000FFF, 8'h3C, 1'b0, 1'b0);
        send_item(OP_READ,  24'hFFFFFF, 8'h00, 1'b0, 1'b0);
        send_item(OP_READ,  24'h7FF000, 8'h00, 1'b0, 1'b0);
        send_item(OP_WRITE, 24'hFFF000, 8'h00, 1'b1, 1'b1);
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b0);
        send_item(OP_TICK,  24'h000000, 8'h00, 1'b0, 1'b0);
        drain();

        foreach (phase_delay[p])
        begin
            set_flush_delay(CFG_W'(phase_delay[p]));
            repeat (PHASE_ITEMS) random_item();
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
